// ===== rtl/ast_pkg.sv =====
// Shared types, widths and constants for the angular spectrum transfer multiply.
// Holds the CORDIC arctangent table and the side data word that rides the pipeline.
// No dependencies.
package ast_pkg;

    localparam int AST_GRID_SIZE = 1024;
    localparam int IDX_W   = 10;
    localparam int SPEC_W  = 24;
    localparam int COEF_W  = 40;
    localparam int WAVE_W  = 48;
    localparam int CFG_W   = 48;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_SQ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAVE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRESNEL = 2'd3;

    localparam logic MODE_EXACT = 1'b0;

    // square root datapath
    localparam int RAD_W   = 62;
    localparam int ROOT_W  = 31;
    localparam int REM_W   = 33;
    localparam int SQRT_STEPS = 31;

    // rotation datapath
    localparam int CORDIC_STEPS = 24;
    localparam int XY_W = 34;
    localparam int Z_W  = 33;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam int TRIG_W = 19;

    typedef struct packed {
        logic signed [SPEC_W-1:0] a;
        logic signed [SPEC_W-1:0] b;
        logic                     evan;
        logic [1:0]               quad;
        logic [31:0]              fph;
    } t_side;

    function automatic logic [31:0] ast_atan(input int k);
        logic [31:0] r;
        case (k)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051D;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2F9;
            15: r = 32'h0000517C;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A2F;
            19: r = 32'h00000517;
            20: r = 32'h0000028B;
            21: r = 32'h00000145;
            22: r = 32'h000000A2;
            23: r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/ast_sqrt_cell.sv =====
// One digit step of the restoring integer square root, registered.
// Depends on ast_pkg.
module ast_sqrt_cell
    import ast_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [ROOT_W-1:0] i_root,
    input  logic [RAD_W-1:0]  i_rad,
    input  t_side             i_side,
    output logic              o_vld,
    output logic [REM_W-1:0]  o_rem,
    output logic [ROOT_W-1:0] o_root,
    output logic [RAD_W-1:0]  o_rad,
    output t_side             o_side
);
    logic [REM_W+1:0] rem2;
    logic [REM_W-1:0] trial;
    logic             ge;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [RAD_W-1:0]  r_rad;
    t_side             r_side;
    logic              r_vld;

    assign rem2  = {i_rem, i_rad[RAD_W-1 -: 2]};
    assign trial = {i_root, 2'b01};
    assign ge    = rem2 >= {2'b00, trial};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= ge ? REM_W'(rem2 - {2'b00, trial}) : REM_W'(rem2);
            r_root <= {i_root[ROOT_W-2:0], ge};
            r_rad  <= {i_rad[RAD_W-3:0], 2'b00};
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;
    assign o_side = r_side;
endmodule

// ===== rtl/ast_cordic_cell.sv =====
// One rotation step of the CORDIC, registered; STEP sets shift and angle.
// Depends on ast_pkg.
module ast_cordic_cell
    import ast_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic signed [XY_W-1:0] i_x,
    input  logic signed [XY_W-1:0] i_y,
    input  logic signed [Z_W-1:0]  i_z,
    input  t_side                  i_side,
    output logic                   o_vld,
    output logic signed [XY_W-1:0] o_x,
    output logic signed [XY_W-1:0] o_y,
    output logic signed [Z_W-1:0]  o_z,
    output t_side                  o_side
);
    localparam logic signed [Z_W-1:0] ANG = Z_W'(ast_atan(STEP));

    logic signed [XY_W-1:0] dx, dy;
    logic signed [XY_W-1:0] r_x, r_y;
    logic signed [Z_W-1:0]  r_z;
    t_side                  r_side;
    logic                   r_vld;

    assign dx = i_y >>> STEP;
    assign dy = i_x >>> STEP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_z[Z_W-1]) begin
                r_x <= i_x - dx;
                r_y <= i_y + dy;
                r_z <= i_z - ANG;
            end else begin
                r_x <= i_x + dx;
                r_y <= i_y - dy;
                r_z <= i_z + ANG;
            end
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_side = r_side;
endmodule

// ===== rtl/angular_spectrum_transfer_multiply.sv =====
// Angular spectrum transfer multiply: takes one spectrum word per cycle unless stalled,
// maps its row and column to signed frequencies, forms the exact or Fresnel phase and
// multiplies the bin by the unit phasor. Throughput is one word per clock when the
// output is not stalled. The pipeline holds 5 index and product stages, a chain of 31 square root
// cells, 2 phase stages, a chain of 24 CORDIC cells and 3 multiply and round
// stages. The whole pipeline stalls together when the output word is not taken.
// Depends on ast_pkg, ast_sqrt_cell and ast_cordic_cell.
module angular_spectrum_transfer_multiply
    import ast_pkg::*;
#(
    parameter int GRID_SIZE = AST_GRID_SIZE
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [IDX_W-1:0]         i_row_index,
    input  logic [IDX_W-1:0]         i_col_index,
    input  logic signed [SPEC_W-1:0] i_spec_re,
    input  logic signed [SPEC_W-1:0] i_spec_im,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [SPEC_W-1:0] o_prod_re,
    output logic signed [SPEC_W-1:0] o_prod_im,
    output logic                     o_evanescent
);
    localparam int UW = $clog2(GRID_SIZE) + 1;
    localparam int RW = 2 * UW;
    localparam int HALF = GRID_SIZE / 2;
    localparam int PW = 20 + RW;
    localparam logic [63:0] ONE_Q40 = 64'd1 << 40;

    // configuration
    logic              r_mode;
    logic [COEF_W-1:0] r_freq_sq, r_fresnel;
    logic [WAVE_W-1:0] r_wave;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_freq_sq <= '0;
            r_wave    <= '0;
            r_fresnel <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:    r_mode    <= i_cfg_data[0];
                REG_FREQ_SQ: r_freq_sq <= i_cfg_data[COEF_W-1:0];
                REG_WAVE:    r_wave    <= i_cfg_data[WAVE_W-1:0];
                REG_FRESNEL: r_fresnel <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic r_out_vld;
    assign en      = !r_out_vld || i_ready;
    assign o_ready = en;

    // stage 1: signed frequencies
    logic [IDX_W-1:0]   row_m, col_m;
    logic signed [UW-1:0] u_n, v_n;
    logic signed [UW-1:0] r_u, r_v;
    t_side              side_in, r_sd1;
    logic               r_v1;

    assign row_m = IDX_W'(i_row_index % GRID_SIZE);
    assign col_m = IDX_W'(i_col_index % GRID_SIZE);
    assign u_n = (int'(row_m) <= HALF) ? UW'(row_m) : UW'(row_m) - UW'(GRID_SIZE);
    assign v_n = (int'(col_m) <= HALF) ? UW'(col_m) : UW'(col_m) - UW'(GRID_SIZE);

    always_comb begin
        side_in      = '0;
        side_in.a    = i_spec_re;
        side_in.b    = i_spec_im;
    end

    // stage 2: r2, stage 3: partial products, stage 4: full product, stage 5: root argument
    logic [RW-1:0]     r_r2;
    logic [COEF_W-1:0] coef;
    logic [PW-1:0]     r_pp_hi, r_pp_lo;
    logic [63:0]       r_p;
    logic [RAD_W-1:0]  r_rad;
    logic [63:0]       fres_diff;
    t_side             r_sd2, r_sd3, r_sd4, r_sd5;
    t_side             n_sd5;
    logic              r_v2, r_v3, r_v4, r_v5;

    assign coef      = (r_mode == MODE_EXACT) ? r_freq_sq : r_fresnel;
    assign fres_diff = {r_wave, 16'b0} - r_p;

    always_comb begin
        n_sd5      = r_sd4;
        n_sd5.evan = (r_mode == MODE_EXACT) && (r_p > ONE_Q40);
        n_sd5.fph  = fres_diff[39:8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u     <= u_n;
            r_v     <= v_n;
            r_sd1   <= side_in;
            r_r2    <= RW'(r_u * r_u) + RW'(r_v * r_v);
            r_sd2   <= r_sd1;
            r_pp_hi <= PW'(coef[39:20] * r_r2);
            r_pp_lo <= PW'(coef[19:0] * r_r2);
            r_sd3   <= r_sd2;
            r_p     <= 64'({r_pp_hi, 20'b0}) + 64'(r_pp_lo);
            r_sd4   <= r_sd3;
            r_rad   <= RAD_W'({ONE_Q40[40:0] - r_p[40:0], 20'b0});
            r_sd5   <= n_sd5;
        end
    end

    // square root chain
    logic              sq_vld  [SQRT_STEPS+1];
    logic [REM_W-1:0]  sq_rem  [SQRT_STEPS+1];
    logic [ROOT_W-1:0] sq_root [SQRT_STEPS+1];
    logic [RAD_W-1:0]  sq_rad  [SQRT_STEPS+1];
    t_side             sq_side [SQRT_STEPS+1];

    assign sq_vld[0]  = r_v5;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = r_rad;
    assign sq_side[0] = r_sd5;

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        ast_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_vld  (sq_vld[g]),
            .i_rem  (sq_rem[g]),
            .i_root (sq_root[g]),
            .i_rad  (sq_rad[g]),
            .i_side (sq_side[g]),
            .o_vld  (sq_vld[g+1]),
            .o_rem  (sq_rem[g+1]),
            .o_root (sq_root[g+1]),
            .o_rad  (sq_rad[g+1]),
            .o_side (sq_side[g+1])
        );
    end

    // phase: wave_turns times root, split in two halves
    logic [54:0] r_mh, r_ml;
    logic [53:0] wsum;
    logic [31:0] r_phase;
    t_side       r_sd6, r_sd7;
    logic        r_v6, r_v7;

    assign wsum = {r_mh[29:0], 24'b0} + r_ml[53:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (en) begin
            r_v6 <= sq_vld[SQRT_STEPS];
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mh    <= 55'(r_wave[47:24] * sq_root[SQRT_STEPS]);
            r_ml    <= 55'(r_wave[23:0] * sq_root[SQRT_STEPS]);
            r_sd6   <= sq_side[SQRT_STEPS];
            r_phase <= (r_mode == MODE_EXACT) ? wsum[53:22] : r_sd6.fph;
            r_sd7   <= r_sd6;
        end
    end

    // CORDIC chain
    logic                   co_vld  [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] co_x    [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] co_y    [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  co_z    [CORDIC_STEPS+1];
    t_side                  co_side [CORDIC_STEPS+1];

    always_comb begin
        co_side[0]      = r_sd7;
        co_side[0].quad = r_phase[31:30];
    end
    assign co_vld[0] = r_v7;
    assign co_x[0]   = CORDIC_GAIN;
    assign co_y[0]   = '0;
    assign co_z[0]   = Z_W'({1'b0, r_phase[29:0]});

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        ast_cordic_cell #(.STEP(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_vld  (co_vld[g]),
            .i_x    (co_x[g]),
            .i_y    (co_y[g]),
            .i_z    (co_z[g]),
            .i_side (co_side[g]),
            .o_vld  (co_vld[g+1]),
            .o_x    (co_x[g+1]),
            .o_y    (co_y[g+1]),
            .o_z    (co_z[g+1]),
            .o_side (co_side[g+1])
        );
    end

    // round to Q1.16, saturate, unfold quadrant
    logic signed [XY_W-1:0]   xr, yr;
    logic signed [TRIG_W-1:0] c_sat, s_sat, c_q, s_q;
    logic signed [TRIG_W-1:0] r_c, r_s;
    t_side                    r_sd8, r_sd9;
    logic                     r_v8, r_v9;
    localparam logic signed [XY_W-1:0] TRIG_MAX = 34'sd131071;
    localparam logic signed [XY_W-1:0] TRIG_MIN = -34'sd131072;

    assign xr = (co_x[CORDIC_STEPS] + XY_W'(8192)) >>> 14;
    assign yr = (co_y[CORDIC_STEPS] + XY_W'(8192)) >>> 14;
    assign c_sat = (xr > TRIG_MAX) ? TRIG_W'(TRIG_MAX) :
                   (xr < TRIG_MIN) ? TRIG_W'(TRIG_MIN) : TRIG_W'(xr);
    assign s_sat = (yr > TRIG_MAX) ? TRIG_W'(TRIG_MAX) :
                   (yr < TRIG_MIN) ? TRIG_W'(TRIG_MIN) : TRIG_W'(yr);

    always_comb begin
        case (co_side[CORDIC_STEPS].quad)
            2'd0: begin c_q = c_sat;  s_q = s_sat;  end
            2'd1: begin c_q = -s_sat; s_q = c_sat;  end
            2'd2: begin c_q = -c_sat; s_q = -s_sat; end
            default: begin c_q = s_sat; s_q = -c_sat; end
        endcase
    end

    // complex multiply
    localparam int MW = SPEC_W + TRIG_W;
    logic signed [MW-1:0]   r_ac, r_bs, r_as, r_bc;
    logic signed [MW+1:0]   re_sum, im_sum, re_sh, im_sh;
    logic signed [SPEC_W-1:0] re_sat, im_sat;
    logic signed [SPEC_W-1:0] r_pre, r_pim;
    logic                     r_pev;
    localparam logic signed [MW+1:0] OUT_MAX = (MW+2)'(8388607);
    localparam logic signed [MW+1:0] OUT_MIN = -(MW+2)'(8388608);

    assign re_sum = (MW+2)'(r_ac) - (MW+2)'(r_bs) + (MW+2)'(32768);
    assign im_sum = (MW+2)'(r_as) + (MW+2)'(r_bc) + (MW+2)'(32768);
    assign re_sh  = re_sum >>> 16;
    assign im_sh  = im_sum >>> 16;
    assign re_sat = (re_sh > OUT_MAX) ? SPEC_W'(OUT_MAX) :
                    (re_sh < OUT_MIN) ? SPEC_W'(OUT_MIN) : SPEC_W'(re_sh);
    assign im_sat = (im_sh > OUT_MAX) ? SPEC_W'(OUT_MAX) :
                    (im_sh < OUT_MIN) ? SPEC_W'(OUT_MIN) : SPEC_W'(im_sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8      <= 1'b0;
            r_v9      <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_v8      <= co_vld[CORDIC_STEPS];
            r_v9      <= r_v8;
            r_out_vld <= r_v9;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c   <= c_q;
            r_s   <= s_q;
            r_sd8 <= co_side[CORDIC_STEPS];
            r_ac  <= MW'(r_sd8.a * r_c);
            r_bs  <= MW'(r_sd8.b * r_s);
            r_as  <= MW'(r_sd8.a * r_s);
            r_bc  <= MW'(r_sd8.b * r_c);
            r_sd9 <= r_sd8;
            // evanescent bins leave as zero
            r_pre <= r_sd9.evan ? '0 : re_sat;
            r_pim <= r_sd9.evan ? '0 : im_sat;
            r_pev <= r_sd9.evan;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_prod_re    = r_pre;
    assign o_prod_im    = r_pim;
    assign o_evanescent = r_pev;
endmodule

// ===== rtl/ast_checker.sv =====
// Port-level checks for the angular spectrum transfer multiply.
// Depends on ast_pkg; bound to the top level below.
module ast_port_checks
    import ast_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_ready,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic signed [SPEC_W-1:0] o_prod_re,
    input logic signed [SPEC_W-1:0] o_prod_im,
    input logic                     o_evanescent
);
    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not track output stall");

    a_evan_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_evanescent) |-> (o_prod_re == 0 && o_prod_im == 0))
        else $error("evanescent word carries nonzero product");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_prod_re) && $stable(o_prod_im)))
        else $error("stalled output word changed");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");
endmodule

bind angular_spectrum_transfer_multiply ast_port_checks u_ast_checker (.*);
